@@ rtl/lcg3_rng_pkg.sv @@
// Shared types, constants and helpers for the three-LCG shuffled uniform generator.
package lcg3_rng_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 97;
    localparam int NUM_GEN             = 3;
    localparam int SEED_W              = 31;
    localparam int FIELD_W             = 18;

    localparam logic [SEED_W-1:0] SEED_RESET = 31'd1;

    // Generator constants: index 0 = coarse generator, 1 = fine, 2 = slot picker
    localparam logic [12:0] LCG_MUL [NUM_GEN] = '{13'd7141, 13'd8121, 13'd4561};
    localparam logic [15:0] LCG_ADD [NUM_GEN] = '{16'd54773, 16'd28411, 16'd51349};
    localparam logic [17:0] LCG_MOD [NUM_GEN] = '{18'd259200, 18'd134456, 18'd243000};

    // floor(2^32 / modulus): the quotient estimate is short by at most one
    localparam logic [15:0] LCG_RECIP [NUM_GEN] = '{
        16'((64'd1 << 32) / 64'd259200),
        16'((64'd1 << 32) / 64'd134456),
        16'((64'd1 << 32) / 64'd243000)
    };

    // Datapath operations
    typedef enum logic [2:0] {
        OP_SEED,
        OP_INIT_TWO,
        OP_INIT_THREE,
        OP_FILL,
        OP_DRAW,
        OP_SLOT
    } t_op;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED,
        S_INIT_TWO,
        S_INIT_THREE,
        S_FILL,
        S_DRAW,
        S_SLOT,
        S_READ,
        S_WRITE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic start;
        t_op  op;
        logic rd;
        logic wr;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic done;
        logic fill_last;
    } t_stat;

    // One conditional subtract: valid when x < 2*m
    function automatic logic [FIELD_W-1:0] cond_sub(input logic [FIELD_W-1:0] x,
                                                    input logic [FIELD_W-1:0] m);
        logic [FIELD_W-1:0] res;
        res = (x >= m) ? (x - m) : x;
        return res;
    endfunction

endpackage

@@ rtl/lcg3_rng_dpath.sv @@
// Datapath: seed register, three generator modulo pipelines, shuffle table, result register.
module lcg3_rng_dpath
    import lcg3_rng_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [SEED_W-1:0]  i_cfg_data,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic [FIELD_W-1:0] o_coarse,
    output logic [FIELD_W-1:0] o_fine
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PAIR_W = 2 * FIELD_W;

    logic [SEED_W-1:0]  r_seed;
    t_op                r_op;
    logic [2:0]         r_vld;
    logic [IDX_W-1:0]   r_fill;
    logic [IDX_W-1:0]   r_slot;
    logic [FIELD_W-1:0] r_gen [NUM_GEN];

    // Modulo pipeline registers, one set per generator
    logic [31:0]        n_v   [NUM_GEN];
    logic [31:0]        r_v   [NUM_GEN];
    logic [15:0]        r_q   [NUM_GEN];
    logic [19:0]        r_vlo [NUM_GEN];
    logic [19:0]        r_r   [NUM_GEN];
    logic [15:0]        r_q3  [NUM_GEN];
    logic [FIELD_W-1:0] rem   [NUM_GEN];
    logic [15:0]        quo   [NUM_GEN];

    logic [PAIR_W-1:0]  r_table [TABLE_DEPTH];
    logic [PAIR_W-1:0]  r_rd_data;
    logic [FIELD_W-1:0] r_coarse;
    logic [FIELD_W-1:0] r_fine;

    logic               done;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [PAIR_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]   slot_clamped;

    // Seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_data;
        end
    end

    // Operation tracking: a three-deep valid shift follows the started operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_op  <= OP_SEED;
        end else begin
            r_vld <= {r_vld[1:0], i_cmd.start};
            if (i_cmd.start) begin
                r_op <= i_cmd.op;
            end
        end
    end

    assign done = r_vld[2];

    // Per-generator pipeline: operand, reciprocal quotient, remainder, correction
    for (genvar g = 0; g < NUM_GEN; g++) begin : g_gen
        logic [47:0] prod;
        logic [33:0] qm_full;
        logic        take;

        always_comb begin
            case (i_cmd.op)
                OP_SEED: n_v[g] = 32'(r_seed) + 32'(LCG_ADD[0]);
                OP_SLOT: n_v[g] = 32'(r_gen[g]) * 32'(TABLE_DEPTH);
                default: n_v[g] = 32'(r_gen[g]) * 32'(LCG_MUL[g]) + 32'(LCG_ADD[g]);
            endcase
        end

        assign prod    = 48'(r_v[g]) * 48'(LCG_RECIP[g]);
        assign qm_full = 34'(r_q[g]) * 34'(LCG_MOD[g]);
        assign take    = (r_r[g] >= 20'(LCG_MOD[g]));
        assign rem[g]  = take ? FIELD_W'(r_r[g] - 20'(LCG_MOD[g])) : r_r[g][FIELD_W-1:0];
        assign quo[g]  = r_q3[g] + 16'(take);

        always_ff @(posedge i_clk) begin
            if (i_cmd.start) begin
                r_v[g] <= n_v[g];
            end
            r_q[g]   <= prod[47:32];
            r_vlo[g] <= r_v[g][19:0];
            // true remainder is below 2*modulus < 2^20, so low bits suffice
            r_r[g]   <= r_vlo[g] - qm_full[19:0];
            r_q3[g]  <= r_q[g];
        end
    end

    assign slot_clamped = (quo[2] > 16'(TABLE_DEPTH - 1)) ? IDX_W'(TABLE_DEPTH - 1)
                                                          : quo[2][IDX_W-1:0];

    // Generator and table-slot write-back at the end of each operation
    always_ff @(posedge i_clk) begin
        if (done) begin
            case (r_op)
                OP_SEED: begin
                    r_gen[0] <= rem[0];
                end
                OP_INIT_TWO: begin
                    r_gen[0] <= rem[0];
                    r_gen[1] <= cond_sub(rem[0], LCG_MOD[1]);
                end
                OP_INIT_THREE: begin
                    r_gen[0] <= rem[0];
                    r_gen[2] <= cond_sub(rem[0], LCG_MOD[2]);
                end
                OP_FILL: begin
                    r_gen[0] <= rem[0];
                    r_gen[1] <= rem[1];
                end
                OP_DRAW: begin
                    r_gen[0] <= rem[0];
                    r_gen[1] <= rem[1];
                    r_gen[2] <= rem[2];
                end
                OP_SLOT: begin
                    r_slot <= slot_clamped;
                end
                default: begin
                end
            endcase
        end
    end

    // Fill pointer for table seeding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (done && (r_op == OP_SEED)) begin
            r_fill <= '0;
        end else if (done && (r_op == OP_FILL)) begin
            r_fill <= r_fill + IDX_W'(1);
        end
    end

    // Shuffle table: one write port, one registered read port; fine in high half
    assign mem_we    = (done && (r_op == OP_FILL)) || i_cmd.wr;
    assign mem_waddr = i_cmd.wr ? r_slot : r_fill;
    assign mem_wdata = i_cmd.wr ? {r_gen[1], r_gen[0]} : {rem[1], rem[0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_table[r_slot];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_coarse <= r_rd_data[FIELD_W-1:0];
            r_fine   <= r_rd_data[PAIR_W-1:FIELD_W];
        end
    end

    assign o_coarse         = r_coarse;
    assign o_fine           = r_fine;
    assign o_stat.done      = done;
    assign o_stat.fill_last = (r_fill == IDX_W'(TABLE_DEPTH - 1));

    // A new operation never starts over one still in flight
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> (r_vld == 3'b000))
        else $error("operation started while pipeline busy");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_vld))
        else $error("more than one operation in flight");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && (r_op == OP_SLOT)) |=> (32'(r_slot) < 32'(TABLE_DEPTH)))
        else $error("table slot out of range");

endmodule

@@ rtl/lcg3_rng_ctrl.sv @@
// Controller: sequences seeding, table fill and draws, and owns the handshakes.
module lcg3_rng_ctrl
    import lcg3_rng_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_request,
    input  logic  i_cfg_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_started;
    logic   n_started;
    logic   r_seeded;
    logic   n_seeded;
    logic   r_out_valid;
    logic   n_out_valid;

    logic   in_xfer;
    logic   out_free;
    logic   run;
    t_state run_next;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_started   = r_started;
        n_seeded    = r_seeded;
        o_cmd       = '0;
        o_cmd.op    = OP_DRAW;
        run         = 1'b0;
        run_next    = S_IDLE;

        case (r_state)
            S_IDLE: begin
                if (in_xfer && i_request) begin
                    n_state = r_seeded ? S_DRAW : S_SEED;
                end
            end
            S_SEED: begin
                o_cmd.op = OP_SEED;
                run      = 1'b1;
                run_next = S_INIT_TWO;
            end
            S_INIT_TWO: begin
                o_cmd.op = OP_INIT_TWO;
                run      = 1'b1;
                run_next = S_INIT_THREE;
            end
            S_INIT_THREE: begin
                o_cmd.op = OP_INIT_THREE;
                run      = 1'b1;
                run_next = S_FILL;
            end
            S_FILL: begin
                o_cmd.op = OP_FILL;
                run      = 1'b1;
                run_next = i_stat.fill_last ? S_DRAW : S_FILL;
                if (r_started && i_stat.done && i_stat.fill_last) begin
                    n_seeded = 1'b1;
                end
            end
            S_DRAW: begin
                o_cmd.op = OP_DRAW;
                run      = 1'b1;
                run_next = S_SLOT;
            end
            S_SLOT: begin
                o_cmd.op = OP_SLOT;
                run      = 1'b1;
                run_next = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WRITE;
            end
            S_WRITE: begin
                // refill the slot and load the result once the output register frees
                if (out_free) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Shared start / wait-for-done handling of datapath operations
        if (run) begin
            if (!r_started) begin
                o_cmd.start = 1'b1;
                n_started   = 1'b1;
            end else if (i_stat.done) begin
                n_started = 1'b0;
                n_state   = run_next;
            end
        end

        if (i_cfg_valid) begin
            n_seeded = 1'b0;
        end
    end

    // Output valid
    always_comb begin
        if (o_cmd.wr) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Done only comes back for an operation this controller started
    a_done_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.done |-> r_started)
        else $error("datapath done without a started operation");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr |-> out_free)
        else $error("result register overwritten");

    a_wr_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("result load did not raise output valid");

endmodule

@@ rtl/three_lcg_shuffled_uniform_rng_core.sv @@
// Top level of the three-LCG shuffled uniform random generator.
// Each accepted request with i_request high yields one pair (coarse, fine) meaning
// (coarse + fine/134456)/259200; an item with i_request low is taken and yields nothing.
// Every generator step runs through a reciprocal-multiply modulo pipeline (operand,
// quotient, remainder, correction), so a draw on a seeded block runs these steps from
// one input transfer to the next: one step of all three generators, one pass for the
// table slot, a table read and a table write. The first draw after reset or after a
// seed write first seeds the generators and fills the table before these steps.
// The result sits in an output register, so the next request is taken while it waits.
// The seed register takes a transfer in every cycle; write it only while no draw is
// in flight.
module three_lcg_shuffled_uniform_rng_core
    import lcg3_rng_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SEED_W-1:0]  i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_request,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [FIELD_W-1:0] o_coarse,
    output logic [FIELD_W-1:0] o_fine
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    lcg3_rng_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_request   (i_request),
        .i_cfg_valid (i_cfg_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    lcg3_rng_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_coarse    (o_coarse),
        .o_fine      (o_fine)
    );

endmodule
